// ----- hw/rtl/adc_cbc_pkg.sv -----
// ----------------------------------------------------------------------------
// adc_cbc_pkg
// Types, codes and constants shared by the control byte converter modules.
// ----------------------------------------------------------------------------
package adc_cbc_pkg;

  localparam int NUM_LINES_DEF = 8;
  localparam int MAX_LINES     = 8;

  typedef enum logic [1:0] {
    OP_WRITE_CTRL = 2'd0,
    OP_READ       = 2'd1,
    OP_SET_LEVEL  = 2'd2
  } op_t;

  typedef enum logic {
    CFG_EIGHT_LINE_MODE = 1'b0,
    CFG_COMMON_LEVEL    = 1'b1
  } cfg_idx_t;

  // control byte bit positions
  localparam int CB_PWR   = 1;
  localparam int CB_SGL   = 2;
  localparam int CB_UNI   = 3;
  localparam int CB_SEL0  = 4;
  localparam int CB_SEL1  = 5;
  localparam int CB_SEL2  = 6;
  localparam int CB_TRIG  = 7;

  localparam logic [7:0] BIPOLAR_FLIP = 8'h80;
  localparam logic [7:0] HIGH_MASK    = 8'h3f;
  localparam logic [7:0] LOW_MASK     = 8'hc0;
  localparam logic [7:0] LEVEL_TOP    = 8'hf0;
  localparam logic [7:0] LEVEL_STEP   = 8'h10;

  localparam logic [1:0] PHASE_HIGH = 2'd1;
  localparam logic [1:0] PHASE_LOW  = 2'd2;
  localparam logic [1:0] PHASE_MAX  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [2:0] line_index;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       conversion_done;
  } out_t;

  // level update request from core to line bank
  typedef struct packed {
    logic       en;
    logic [2:0] line;
    logic [7:0] level;
  } lvl_wr_t;

  // the two lines of one differential pair
  typedef struct packed {
    logic [7:0] odd;
    logic [7:0] even;
  } lvl_pair_t;

  function automatic logic [7:0] level_rst(input int idx);
    level_rst = LEVEL_TOP - 8'(LEVEL_STEP * idx);
  endfunction

endpackage

// ----- hw/rtl/adc_cbc_line_bank.sv -----
// ----------------------------------------------------------------------------
// adc_cbc_line_bank
// Analog line levels, read one differential pair at a time.
// ----------------------------------------------------------------------------
module adc_cbc_line_bank #(
  parameter int NUM_LINES = adc_cbc_pkg::NUM_LINES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  adc_cbc_pkg::lvl_wr_t   wr,
  input  logic [1:0]             rd_row,
  output adc_cbc_pkg::lvl_pair_t rd_pair
);
  import adc_cbc_pkg::*;

  logic [7:0] lvl [MAX_LINES];

  for (genvar i = 0; i < MAX_LINES; i++) begin : g_line
    if (i < NUM_LINES) begin : g_reg
      localparam logic [2:0] IDX = 3'(i);
      logic [7:0] lvl_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          lvl_r <= level_rst(i);
        end else if (wr.en && wr.line == IDX) begin
          lvl_r <= wr.level;
        end
      end
      assign lvl[i] = lvl_r;
    end else begin : g_const
      // lines past the count are never written and keep their reset level
      assign lvl[i] = level_rst(i);
    end
  end

  assign rd_pair.even = lvl[{rd_row, 1'b0}];
  assign rd_pair.odd  = lvl[{rd_row, 1'b1}];

endmodule

// ----- hw/rtl/adc_cbc_core.sv -----
// ----------------------------------------------------------------------------
// adc_cbc_core
// Control byte decode, conversion and result byte read sequencing.
// ----------------------------------------------------------------------------
module adc_cbc_core #(
  parameter int NUM_LINES = adc_cbc_pkg::NUM_LINES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  adc_cbc_pkg::in_t       item,
  input  logic                   eight_line_mode,
  input  logic [7:0]             common_level,
  input  adc_cbc_pkg::lvl_pair_t pair,
  output logic [1:0]             rd_row,
  output adc_cbc_pkg::lvl_wr_t   lvl_wr,
  output adc_cbc_pkg::out_t      result
);
  import adc_cbc_pkg::*;

  localparam logic [3:0] COUNT_EIGHT = 4'(NUM_LINES);
  localparam logic [3:0] COUNT_FOUR  = 4'd4;

  logic       held_r, held_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [7:0] lo_r, lo_nxt;

  logic [7:0] cb;
  logic [2:0] chan;
  logic [7:0] self_lvl, pair_lvl, other, measure;
  logic [3:0] count;

  assign cb = item.data_byte;

  always_comb begin
    if (eight_line_mode) begin
      chan = {cb[CB_SEL1], cb[CB_SEL0], cb[CB_SEL2]};
    end else begin
      chan = {1'b0, cb[CB_SEL1], cb[CB_SEL2]};
    end
  end

  assign rd_row   = chan[2:1];
  assign self_lvl = chan[0] ? pair.odd  : pair.even;
  assign pair_lvl = chan[0] ? pair.even : pair.odd;
  assign other    = cb[CB_SGL] ? common_level : pair_lvl;

  always_comb begin
    measure = self_lvl - other;
    if (!cb[CB_UNI]) begin
      measure = measure ^ BIPOLAR_FLIP;
    end
  end

  assign count = eight_line_mode ? COUNT_EIGHT : COUNT_FOUR;

  always_comb begin
    lvl_wr.en    = fire && (item.op == OP_SET_LEVEL) && ({1'b0, item.line_index} < count);
    lvl_wr.line  = item.line_index;
    lvl_wr.level = item.data_byte;
  end

  always_comb begin
    held_nxt               = held_r;
    phase_nxt              = phase_r;
    hi_nxt                 = hi_r;
    lo_nxt                 = lo_r;
    result.read_data       = 8'd0;
    result.conversion_done = 1'b0;
    case (item.op)
      OP_WRITE_CTRL: begin
        if (cb[CB_TRIG]) begin
          phase_nxt = 2'd0;
          if (!cb[CB_PWR]) begin
            held_nxt = 1'b0;
          end else begin
            held_nxt               = 1'b1;
            hi_nxt                 = {2'b00, measure[7:2]} & HIGH_MASK;
            lo_nxt                 = {measure[1:0], 6'd0} & LOW_MASK;
            result.conversion_done = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (held_r) begin
          if (phase_r == PHASE_HIGH) begin
            result.read_data = hi_r;
          end else if (phase_r == PHASE_LOW) begin
            result.read_data = lo_r;
          end
          if (phase_r != PHASE_MAX) begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      phase_r <= 2'd0;
      hi_r    <= 8'd0;
      lo_r    <= 8'd0;
    end else if (fire) begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
    end
  end

endmodule

// ----- hw/rtl/adc_control_byte_converter_unit.sv -----
// ----------------------------------------------------------------------------
// adc_control_byte_converter_unit
// Serial converter digital side: control writes, result reads, level updates.
// ----------------------------------------------------------------------------
// path: an accepted transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle while out_ready does not stall, set by the single input and result register
// reset: synchronous active low; levels 0xf0 down to 0x80, conversion idle,
//   eight line mode on, common level 0; no clearing pass
module adc_control_byte_converter_unit #(
  parameter int NUM_LINES = adc_cbc_pkg::NUM_LINES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  adc_cbc_pkg::in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output adc_cbc_pkg::out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);
  import adc_cbc_pkg::*;

  logic       eight_r;
  logic [7:0] common_r;
  logic       a_valid_r;
  in_t        a_item_r;
  logic       out_valid_r;
  out_t       out_data_r;
  logic       advance;
  lvl_wr_t    lvl_wr;
  lvl_pair_t  pair;
  logic [1:0] rd_row;
  out_t       result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eight_r  <= 1'b1;
      common_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EIGHT_LINE_MODE: eight_r  <= cfg_data[0];
        CFG_COMMON_LEVEL:    common_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input stage moves on whenever the result register is free or drains
  assign advance  = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  adc_cbc_line_bank #(
    .NUM_LINES(NUM_LINES)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (lvl_wr),
    .rd_row  (rd_row),
    .rd_pair (pair)
  );

  adc_cbc_core #(
    .NUM_LINES(NUM_LINES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (advance),
    .item            (a_item_r),
    .eight_line_mode (eight_r),
    .common_level    (common_r),
    .pair            (pair),
    .rd_row          (rd_row),
    .lvl_wr          (lvl_wr),
    .result          (result)
  );

endmodule
